[src/htl_pkg.sv]
// Package for the hash tree layout locator: field widths, item packing,
// codes, controller types and a small helper. No dependencies.
`default_nettype none
package htl_pkg;

  localparam int MaxLevels = 63;
  localparam int AddrW     = 48;   // block address width; lookup sums wrap modulo 2^48, build overflow is flagged

  localparam int OpW    = 2;
  localparam int BlkW   = 48;
  localparam int LvlW   = 6;
  localparam int SectW  = 48;
  localparam int BytesW = 32;
  localparam int StatW  = 3;
  localparam int OffW   = 16;
  localparam int SpanW  = 24;
  localparam int ShW    = 5;
  localparam int AmtW   = LvlW + ShW;

  // s_tdata layout
  localparam int InBlkLo   = 0;
  localparam int InLvlLo   = InBlkLo + BlkW;
  localparam int InSectLo  = InLvlLo + LvlW;
  localparam int InBytesLo = InSectLo + SectW;
  localparam int InWrLo    = InBytesLo + BytesW;
  localparam int InTdataW  = 136;
  localparam int OutTdataW = 192;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] RegFormat    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDataBits  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHashBits  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDigest    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDataCount = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTreeBase  = 3'd5;

  localparam logic [3:0] SectorBits = 4'd9;

  typedef enum logic [OpW-1:0] {
    OP_BUILD, OP_LOCATE, OP_LEVEL_UP, OP_CHECK_WRITE
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_OK, ST_MISALIGNED, ST_OUT_OF_RANGE, ST_TOO_MANY, ST_OVERFLOW,
    ST_DIGEST_BIG, ST_BAD_LEVEL
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_BINIT, S_COUNT, S_WALK, S_LOOK0, S_LOOK1, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_LOAD, CMD_BINIT, CMD_COUNT, CMD_WALK, CMD_LOOK0, CMD_LOOK1,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic digest_big;
    logic count_done;
    logic count_exit;
    logic walk_done;
  } dp_stat_t;

  // ceil(log2(x)) for a digest size, x >= 1
  function automatic logic [2:0] clog2_digest(input logic [6:0] x);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if ((8'd1 << i) < {1'b0, x}) r = 3'(i + 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/htl_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module htl_ram #(
  parameter int W = 48,
  parameter int D = 63,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  q
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) q <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/htl_ctrl.sv]
// Controller state machine of the hash tree layout locator.
// Depends on htl_pkg; drives htl_dpath by command, reads its status.
`default_nettype none
module htl_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [htl_pkg::OpW-1:0] op_in,
  input  wire htl_pkg::dp_stat_t      stat,
  output htl_pkg::cmd_t               cmd
);
  import htl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd = CMD_LOAD;
          case (op_t'(op_in))
            OP_BUILD:       state_next = S_BINIT;
            OP_CHECK_WRITE: state_next = S_DONE;
            default:        state_next = S_LOOK0;
          endcase
        end
      end
      S_BINIT: begin
        cmd        = CMD_BINIT;
        state_next = stat.digest_big ? S_DONE : S_COUNT;
      end
      S_COUNT: begin
        cmd = CMD_COUNT;
        if (stat.count_done) state_next = stat.count_exit ? S_DONE : S_WALK;
      end
      S_WALK: begin
        cmd = CMD_WALK;
        if (stat.walk_done) state_next = S_DONE;
      end
      S_LOOK0: begin
        cmd        = CMD_LOOK0;
        state_next = S_LOOK1;
      end
      S_LOOK1: begin
        cmd        = CMD_LOOK1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd        = CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[src/htl_dpath.sv]
// Datapath: config and tree state registers, build walk, lookup math,
// write check and the output register. Depends on htl_pkg and htl_ram.
`default_nettype none
module htl_dpath #(
  parameter int MAX_LEVELS = htl_pkg::MaxLevels
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [htl_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [htl_pkg::CfgDataW-1:0] cfg_wr_data,
  input  wire logic [htl_pkg::InTdataW-1:0] s_tdata,
  input  wire logic [htl_pkg::OpW-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [htl_pkg::OutTdataW-1:0]    m_tdata,
  output logic [htl_pkg::StatW-1:0]        m_tuser,
  input  wire htl_pkg::cmd_t               cmd,
  output htl_pkg::dp_stat_t                stat
);
  import htl_pkg::*;

  localparam int LAw = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  // configuration
  logic              fv;
  logic [3:0]        dbb;
  logic [4:0]        hbb;
  logic [6:0]        dgst;
  logic [AddrW-1:0]  nblk, base;
  // tree state
  logic [LvlW-1:0]   levels;
  logic [ShW-1:0]    pbs;
  logic [AddrW-1:0]  tend;
  // item
  op_t               op;
  logic [BlkW-1:0]   blk;
  logic [LvlW-1:0]   lvl;
  logic [SectW-1:0]  sector;
  logic [BytesW-1:0] bytes;
  logic              wr;
  // build work
  logic [AddrW-1:0]  v, pos;
  logic [LvlW-1:0]   lv, wi;
  logic [ShW-1:0]    sh;
  logic [AmtW-1:0]   amt;
  status_t           bst;
  // lookup work
  logic [AddrW-1:0]  p, ls0, bo, ram_q;
  // output fields
  status_t           o_status;
  logic [AddrW-1:0]  o_hash, o_tend, o_first;
  logic [OffW-1:0]   o_off;
  logic [LvlW-1:0]   o_lvls;
  logic [SpanW-1:0]  o_span;
  logic              o_rehash;

  // build helpers
  logic              digest_big, too_many;
  logic [ShW-1:0]    sh_calc;
  logic [AddrW-1:0]  s_lvl, cnt;
  logic [AddrW:0]    sum;
  logic [ShW+3:0]    sh_wide;

  assign digest_big = (dgst == 7'd0) || ((33'd1 << hbb) < {25'd0, dgst, 1'b0});
  assign sh_wide    = {4'd0, hbb} - {6'd0, clog2_digest(dgst)};
  assign sh_calc    = sh_wide[ShW-1:0];
  assign too_many   = {1'b0, lv} > 7'(MAX_LEVELS);
  assign s_lvl      = nblk >> amt;
  assign cnt        = (s_lvl >> sh) +
                      AddrW'(|(s_lvl & ((AddrW'(1) << sh) - AddrW'(1))));
  assign sum        = {1'b0, pos} + {1'b0, cnt};

  // lookup helpers
  logic [OffW-1:0]   lowmask16, idx16, boidx16;
  logic [ShW-1:0]    ss;
  logic              bad_loc, bad_up;
  logic [LvlW:0]     lvl_up;
  logic [OffW+6:0]   packed_off;

  assign lowmask16  = OffW'((32'd1 << pbs) - 32'd1);
  assign ss         = (hbb > pbs) ? hbb - pbs : '0;
  assign lvl_up     = {1'b0, lvl} + 7'd1;
  assign bad_loc    = lvl >= levels;
  assign bad_up     = lvl_up >= {1'b0, levels};
  assign idx16      = p[OffW-1:0] & lowmask16;
  assign boidx16    = bo[OffW-1:0] & lowmask16;
  assign packed_off = idx16 * dgst;

  // write check helpers
  logic [3:0]       db;
  logic [2:0]       sb;
  logic [SectW-1:0] first;
  logic [BytesW-1:0] span32;
  logic             mis, oor;

  assign db     = (dbb < SectorBits) ? SectorBits : dbb;
  assign sb     = 3'(db - SectorBits);
  assign first  = sector >> sb;
  assign span32 = bytes >> db;
  assign mis    = (|(bytes & ((32'd1 << db) - 32'd1))) |
                  (|(sector & ((SectW'(1) << sb) - SectW'(1))));
  assign oor    = ({1'b0, first} + {25'd0, span32[SpanW-1:0]}) > {1'b0, nblk};

  // level start table
  logic           ram_we, ram_re;
  logic [LAw-1:0] ram_raddr;

  assign ram_we    = (cmd == CMD_WALK);
  assign ram_re    = ((cmd == CMD_LOOK0) && !bad_loc) ||
                     ((cmd == CMD_LOOK1) && (op == OP_LEVEL_UP) && !bad_up);
  assign ram_raddr = (cmd == CMD_LOOK1) ? lvl_up[LAw-1:0] : lvl[LAw-1:0];

  htl_ram #(.W(AddrW), .D(MAX_LEVELS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi[LAw-1:0]),
    .wdata (pos),
    .re    (ram_re),
    .raddr (ram_raddr),
    .q     (ram_q)
  );

  always_comb begin
    stat.out_free   = !m_tvalid || m_tready;
    stat.digest_big = digest_big;
    stat.count_done = (v == '0);
    stat.count_exit = too_many || (lv == '0);
    stat.walk_done  = sum[AddrW] || (wi == '0);
  end

  // result of the item being finished; unused fields stay zero
  status_t          r_status;
  logic [AddrW-1:0] r_hash, r_tend, r_first;
  logic [OffW-1:0]  r_off;
  logic [LvlW-1:0]  r_lvls;
  logic [SpanW-1:0] r_span;
  logic             r_rehash;

  always_comb begin
    r_status = ST_OK;
    r_hash   = '0;
    r_off    = '0;
    r_lvls   = '0;
    r_tend   = '0;
    r_first  = '0;
    r_span   = '0;
    r_rehash = 1'b0;
    case (op)
      OP_BUILD: begin
        r_status = bst;
        r_lvls   = levels;
        r_tend   = tend;
      end
      OP_LOCATE: begin
        if (bad_loc) begin
          r_status = ST_BAD_LEVEL;
        end else begin
          r_hash = ls0 + (p >> pbs);
          r_off  = fv ? (idx16 << ss) : packed_off[OffW-1:0];
        end
      end
      OP_LEVEL_UP: begin
        if (bad_up) begin
          r_status = ST_BAD_LEVEL;
        end else begin
          r_hash = ram_q + (bo >> pbs);
          r_off  = boidx16 << ss;
        end
      end
      default: begin
        if (wr && (bytes != '0)) begin
          if (mis) begin
            r_status = ST_MISALIGNED;
          end else if (oor) begin
            r_status = ST_OUT_OF_RANGE;
          end else begin
            r_first  = first;
            r_span   = span32[SpanW-1:0];
            r_rehash = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv       <= 1'b1;
      dbb      <= 4'd12;
      hbb      <= 5'd12;
      dgst     <= 7'd32;
      nblk     <= '0;
      base     <= '0;
      levels   <= '0;
      pbs      <= '0;
      tend     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          RegFormat:    fv   <= cfg_wr_data[0];
          RegDataBits:  dbb  <= cfg_wr_data[3:0];
          RegHashBits:  hbb  <= cfg_wr_data[4:0];
          RegDigest:    dgst <= cfg_wr_data[6:0];
          RegDataCount: nblk <= cfg_wr_data[AddrW-1:0];
          RegTreeBase:  base <= cfg_wr_data[AddrW-1:0];
          default: ;
        endcase
      end
      if (cmd == CMD_FINISH)          m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready)  m_tvalid <= 1'b0;

      case (cmd)
        CMD_LOAD: begin
          op     <= op_t'(s_tuser);
          blk    <= s_tdata[InBlkLo +: BlkW];
          lvl    <= s_tdata[InLvlLo +: LvlW];
          sector <= s_tdata[InSectLo +: SectW];
          bytes  <= s_tdata[InBytesLo +: BytesW];
          wr     <= s_tdata[InWrLo];
        end
        CMD_BINIT: begin
          levels <= '0;
          pbs    <= '0;
          tend   <= '0;
          bst    <= digest_big ? ST_DIGEST_BIG : ST_OK;
          sh     <= sh_calc;
          v      <= (nblk == '0) ? '0 : nblk - AddrW'(1);
          lv     <= '0;
        end
        CMD_COUNT: begin
          if (v != '0) begin
            v  <= v >> sh;
            lv <= lv + LvlW'(1);
          end else if (too_many) begin
            bst <= ST_TOO_MANY;
          end else if (lv == '0) begin
            tend <= base;
            pbs  <= sh;
          end else begin
            wi  <= lv - LvlW'(1);
            amt <= (lv - LvlW'(1)) * sh;
            pos <= base;
          end
        end
        CMD_WALK: begin
          if (sum[AddrW]) begin
            bst <= ST_OVERFLOW;
          end else begin
            pos <= sum[AddrW-1:0];
            if (wi == '0) begin
              levels <= lv;
              pbs    <= sh;
              tend   <= sum[AddrW-1:0];
            end else begin
              wi  <= wi - LvlW'(1);
              amt <= amt - AmtW'(sh);
            end
          end
        end
        CMD_LOOK0: p <= blk >> (AmtW'(lvl) * AmtW'(pbs));
        CMD_LOOK1: begin
          ls0 <= ram_q;
          bo  <= blk - ram_q;
        end
        CMD_FINISH: begin
          o_status <= r_status;
          o_hash   <= r_hash;
          o_off    <= r_off;
          o_lvls   <= r_lvls;
          o_tend   <= r_tend;
          o_first  <= r_first;
          o_span   <= r_span;
          o_rehash <= r_rehash;
        end
        default: ;
      endcase
    end
  end

  assign m_tuser = o_status;
  assign m_tdata = {1'b0, o_rehash, o_span, o_first, o_tend, o_lvls, o_off, o_hash};
endmodule
`default_nettype wire

[src/hash_tree_layout_locator.sv]
// Top level of the hash tree layout locator: controller plus datapath.
// Depends on htl_pkg, htl_ctrl, htl_dpath (which holds htl_ram).
// Path from accept to result valid: check_write goes straight to the output
// register, locate and level_up pass the table reads, build_layout its init,
// level count and walk. One item in flight; the next is taken once the result
// is registered, while it waits on m_tready.
// Reset (rst, sync, active high): config registers to their defaults, tree empty.
`default_nettype none
module hash_tree_layout_locator #(
  parameter int MAX_LEVELS = htl_pkg::MaxLevels
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration write port
  input  wire logic                        cfg_wr_en,
  input  wire logic [htl_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [htl_pkg::CfgDataW-1:0] cfg_wr_data,
  // input items
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // block_number, tree_level, start_sector, byte_count, is_write, pad
  input  wire logic [htl_pkg::InTdataW-1:0] s_tdata,
  // operation
  input  wire logic [htl_pkg::OpW-1:0]      s_tuser,
  // result items
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // node_block, entry_offset, level_count, tree_end_block, first_block,
  // block_span, needs_rehash, pad
  output logic [htl_pkg::OutTdataW-1:0]    m_tdata,
  // status
  output logic [htl_pkg::StatW-1:0]        m_tuser
);
  import htl_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  // The controller sequences: build = init, level count (one shift per level),
  // top-down walk (one level start written per cycle); locate = one table read,
  // level_up = two; then, once the output is free, the output register loads.
  htl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op_in    (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  htl_dpath #(.MAX_LEVELS(MAX_LEVELS)) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cmd         (cmd),
    .stat        (stat)
  );
endmodule
`default_nettype wire

[src/htl_checker.sv]
// Port-level checks for hash_tree_layout_locator, bound to the top level.
// Depends on htl_pkg.
`default_nettype none
module htl_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [htl_pkg::OutTdataW-1:0] m_tdata,
  input wire logic [htl_pkg::StatW-1:0]     m_tuser
);
  import htl_pkg::*;

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= StatW'(ST_BAD_LEVEL))
    else $error("status code out of range");

  a_rehash_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[190] |-> m_tuser == StatW'(ST_OK))
    else $error("rehash flagged on a failed write");
endmodule

bind hash_tree_layout_locator htl_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
